// File: hw/rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, command codes and helpers for the point partition block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // Store depth default and point dimensions
  localparam int unsigned PointDepthDefault = 1024;
  localparam int unsigned Dimensions        = 3;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PART  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // One stored point, signed Q2.30 per coordinate
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // One result word
  typedef struct packed {
    logic   status;
    point_t pt;
  } res_t;

  // Coordinate on the selected axis (axis is checked before use)
  function automatic logic signed [31:0] coord_sel(input point_t p, input logic [1:0] axis);
    logic signed [31:0] c;
    case (axis)
      AXIS_X:  c = p.x;
      AXIS_Y:  c = p.y;
      AXIS_Z:  c = p.z;
      default: c = p.x;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/ppp_mem.sv
// ----------------------------------------------------------------------------
// ppp_mem
// Point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppp_mem import ppp_pkg::*; #(
  parameter int unsigned POINT_DEPTH = PointDepthDefault,
  localparam int unsigned AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  point_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output point_t        rdata_o
);

  point_t mem_q [POINT_DEPTH];
  point_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ppp_seq.sv
// ----------------------------------------------------------------------------
// ppp_seq
// Command sequencer: decodes commands, walks the two partition pointers and
// drives the single store port pair with one shared coordinate compare.
// ----------------------------------------------------------------------------
module ppp_seq import ppp_pkg::*; #(
  parameter int unsigned POINT_DEPTH = PointDepthDefault,
  localparam int unsigned AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1,
  localparam int unsigned CW = ($clog2(POINT_DEPTH + 1) > 11) ? $clog2(POINT_DEPTH + 1) : 11,
  localparam int unsigned PW = CW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command side
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [1:0]         axis_i,
  input  logic signed [31:0] split_i,
  input  logic [10:0]        range_start_i,
  input  logic [10:0]        range_end_i,
  // result side
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o,
  // store port
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output point_t             wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  point_t             rdata_i
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDOUT = 3'd1;
  localparam logic [2:0] ST_LOADI = 3'd2;
  localparam logic [2:0] ST_CMPI  = 3'd3;
  localparam logic [2:0] ST_CMPJ  = 3'd4;
  localparam logic [2:0] ST_WRJ   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [CW-1:0]        DepthC = CW'(POINT_DEPTH);
  localparam logic signed [PW-1:0] One    = PW'(1);

  logic [2:0]         state_q, state_d;
  logic signed [PW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0]         axis_q, axis_d;
  logic signed [31:0] split_q, split_d;
  point_t             pi_q, pi_d;
  res_t               res_q, res_d;

  logic [CW-1:0]        idx_ext, start_ext, end_ext;
  logic                 idx_ok, range_ok;
  logic signed [31:0]   coord;
  logic signed [PW-1:0] j_dec;

  assign idx_ext   = CW'(index_i);
  assign start_ext = CW'(range_start_i);
  assign end_ext   = CW'(range_end_i);
  assign idx_ok    = idx_ext < DepthC;
  assign range_ok  = (axis_i < 2'(Dimensions)) && (start_ext <= end_ext) && (end_ext <= DepthC);

  // Shared compare operand: coordinate of the word just read
  assign coord = coord_sel(rdata_i, axis_q);
  assign j_dec = j_q - One;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // Next state and store port control
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    axis_d  = axis_q;
    split_d = split_q;
    pi_d    = pi_q;
    res_d   = res_q;
    we_o    = 1'b0;
    waddr_o = i_q[AW-1:0];
    wdata_o = rdata_i;
    raddr_o = i_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{status: STATUS_OK, pt: '0};
          state_d = ST_DONE;
          case (cmd_i)
            CMD_WRITE: begin
              if (idx_ok) begin
                we_o    = 1'b1;
                waddr_o = idx_ext[AW-1:0];
                wdata_o = '{x: coord_x_i, y: coord_y_i, z: coord_z_i};
              end else begin
                res_d.status = STATUS_BAD;
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                raddr_o = idx_ext[AW-1:0];
                state_d = ST_RDOUT;
              end else begin
                res_d.status = STATUS_BAD;
              end
            end
            CMD_PART: begin
              if (range_ok) begin
                i_d     = signed'({1'b0, start_ext});
                j_d     = signed'({1'b0, end_ext}) - One;
                axis_d  = axis_i;
                split_d = split_i;
                state_d = ST_LOADI;
              end else begin
                res_d.status = STATUS_BAD;
              end
            end
            default: res_d.status = STATUS_BAD;
          endcase
        end
      end
      ST_RDOUT: begin
        res_d.pt = rdata_i;
        state_d  = ST_DONE;
      end
      // Loop test, then fetch left point
      ST_LOADI: begin
        if (i_q < j_q) begin
          raddr_o = i_q[AW-1:0];
          state_d = ST_CMPI;
        end else begin
          state_d = ST_DONE;
        end
      end
      // Left point below split: advance; else fetch right point
      ST_CMPI: begin
        pi_d = rdata_i;
        if (coord < split_q) begin
          i_d     = i_q + One;
          state_d = ST_LOADI;
        end else begin
          raddr_o = j_q[AW-1:0];
          state_d = ST_CMPJ;
        end
      end
      // Right point above split: retreat; else swap, right word into left slot
      ST_CMPJ: begin
        if (coord > split_q) begin
          j_d = j_dec;
          if (i_q < j_dec) begin
            raddr_o = j_dec[AW-1:0];
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          we_o    = 1'b1;
          waddr_o = i_q[AW-1:0];
          wdata_o = rdata_i;
          state_d = ST_WRJ;
        end
      end
      // Second half of swap, then move both pointers
      ST_WRJ: begin
        we_o    = 1'b1;
        waddr_o = j_q[AW-1:0];
        wdata_o = pi_q;
        i_d     = i_q + One;
        j_d     = j_dec;
        state_d = ST_LOADI;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    axis_q  <= axis_d;
    split_q <= split_d;
    pi_q    <= pi_d;
    res_q   <= res_d;
  end

endmodule

// File: hw/rtl/point_partition_by_plane_top.sv
// ----------------------------------------------------------------------------
// point_partition_by_plane_top
// Point store with write, read and plane partition commands.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   command  | in_valid_i / in_ready_o  | cmd, index, coord_x/y/z, axis,
//            |                          | split, range_start, range_end
//   result   | out_valid_o / out_ready_i| point_x/y/z, status
//
// Write and rejected commands go straight to the result state, read passes
// through a read-out state first; each then enters the output register.
// Partition steps the left pointer through the load and compare-left states,
// the right pointer in compare-right alone, and swaps two points through load,
// compare-left, compare-right and write states; the single read port of the
// point store sets this order. One command is in flight at a time.
// Reset clears control only; store contents are undefined until written. A
// stalled result holds in the output register; the sequencer waits on it.
module point_partition_by_plane_top import ppp_pkg::*; #(
  parameter int unsigned POINT_DEPTH = PointDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [1:0]         axis_i,
  input  logic signed [31:0] split_i,
  input  logic [10:0]        range_start_i,
  input  logic [10:0]        range_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic               status_o
);

  localparam int unsigned AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  point_t        wdata, rdata;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_q;
  res_t          out_q;

  ppp_seq #(
    .POINT_DEPTH(POINT_DEPTH)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .index_i,
    .coord_x_i,
    .coord_y_i,
    .coord_z_i,
    .axis_i,
    .split_i,
    .range_start_i,
    .range_end_i,
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  ppp_mem #(
    .POINT_DEPTH(POINT_DEPTH)
  ) u_mem (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register: takes a result word when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = out_q.pt.x;
  assign point_y_o   = out_q.pt.y;
  assign point_z_o   = out_q.pt.z;
  assign status_o    = out_q.status;

endmodule

// File: tb/sv/point_partition_by_plane_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_partition_by_plane_top_tb
// Self-checking bench for the point store with write, read and partition.
// A scoreboard keeps its own copy of the point store, replays every accepted
// command word on it and checks each result word field by field, in order.
// Stimulus only reads or partitions slots that were written before, and
// mixes valid commands with unknown commands, bad axes and bad ranges. Both
// channels idle at random in phases.
// ----------------------------------------------------------------------------
module point_partition_by_plane_top_tb;
  import ppp_pkg::*;

  localparam int unsigned Depth       = PointDepthDefault;
  localparam int          RandomWords = 580;
  localparam int          PhaseWords  = 48;
  localparam int          DrainCycles = 16;
  localparam int          CycleLimit  = 2_000_000;

  // Codes that the package does not name
  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam logic [1:0] AxisBad    = 2'd3;

  // Windows the random part keeps filled
  localparam int LoTop    = 63;
  localparam int HiBottom = 960;

  // One command word as driven on the input channel
  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [1:0]         axis;
    logic signed [31:0] split;
    logic [10:0]        range_start;
    logic [10:0]        range_end;
  } point_cmd_t;

  // Scoreboard: shadow point store and the queue of pending result words
  class part_scoreboard;
    point_t slots[Depth];
    res_t   expected_results[$];
    int     mismatch_count;
    int     lines_printed;

    function new();
      mismatch_count = 0;
      lines_printed  = 0;
    endfunction

    function logic signed [31:0] coord_on(point_t p, logic [1:0] ax);
      case (ax)
        AXIS_X:  return p.x;
        AXIS_Y:  return p.y;
        default: return p.z;
      endcase
    endfunction

    // Two-pointer partition of [lo, hi) about plane; returns the status
    function logic partition_range(logic [1:0] ax, int lo, int hi,
                                   logic signed [31:0] plane);
      int     i;
      int     j;
      point_t tmp;
      if (ax == AxisBad || lo > hi || hi > Depth) return STATUS_BAD;
      i = lo;
      j = hi - 1;
      while (i < j) begin
        if (coord_on(slots[i], ax) < plane) begin
          i++;
        end else if (coord_on(slots[j], ax) > plane) begin
          j--;
        end else begin
          tmp      = slots[i];
          slots[i] = slots[j];
          slots[j] = tmp;
          i++;
          j--;
        end
      end
      return STATUS_OK;
    endfunction

    // Accepted command word: update the shadow store, queue the result
    function void note_command(point_cmd_t w);
      res_t r;
      r = '0;
      case (w.cmd)
        CMD_WRITE: begin
          if (w.index < Depth) begin
            slots[w.index].x = w.coord_x;
            slots[w.index].y = w.coord_y;
            slots[w.index].z = w.coord_z;
          end else begin
            r.status = STATUS_BAD;
          end
        end
        CMD_PART: begin
          r.status = partition_range(w.axis, int'(w.range_start), int'(w.range_end),
                                     w.split);
        end
        CMD_READ: begin
          if (w.index < Depth) r.pt = slots[w.index];
          else r.status = STATUS_BAD;
        end
        default: r.status = STATUS_BAD;
      endcase
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (lines_printed < 30) begin
        lines_printed++;
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endtask

    // Result word taken from the output channel
    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing pending");
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %b want %b", got.status, want.status));
      if (got.pt.x !== want.pt.x)
        report_mismatch($sformatf("point_x got %h want %h", got.pt.x, want.pt.x));
      if (got.pt.y !== want.pt.y)
        report_mismatch($sformatf("point_y got %h want %h", got.pt.y, want.pt.y));
      if (got.pt.z !== want.pt.z)
        report_mismatch($sformatf("point_z got %h want %h", got.pt.z, want.pt.z));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [9:0]         index_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic signed [31:0] coord_z_i;
  logic [1:0]         axis_i;
  logic signed [31:0] split_i;
  logic [10:0]        range_start_i;
  logic [10:0]        range_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] point_x_o;
  logic signed [31:0] point_y_o;
  logic signed [31:0] point_z_o;
  logic               status_o;

  part_scoreboard sb;

  // Stimulus state: which slots hold a point, fill pointers, idle rates
  bit slot_written[Depth];
  int lo_fill;
  int hi_fill;
  int src_idle_pct;
  int sink_stall_pct;
  int cycle_count;

  point_partition_by_plane_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .axis_i       (axis_i),
    .split_i      (split_i),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .status_o     (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Coordinate or split: full range, a few small values for ties, extremes
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(3))
      0, 1: return $urandom();
      2:    return int'($urandom_range(4)) - 2;
      default: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // All fields random; callers override what the command uses
  function automatic point_cmd_t random_word();
    point_cmd_t w;
    w.cmd         = 2'($urandom_range(3));
    w.index       = 10'($urandom_range(Depth - 1));
    w.coord_x     = $urandom();
    w.coord_y     = $urandom();
    w.coord_z     = $urandom();
    w.axis        = 2'($urandom_range(3));
    w.split       = $urandom();
    w.range_start = 11'($urandom_range(2047));
    w.range_end   = 11'($urandom_range(2047));
    return w;
  endfunction

  function automatic point_cmd_t write_word(int idx, logic signed [31:0] x,
                                            logic signed [31:0] y,
                                            logic signed [31:0] z);
    point_cmd_t w;
    w         = random_word();
    w.cmd     = CMD_WRITE;
    w.index   = 10'(idx);
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    slot_written[idx] = 1'b1;
    return w;
  endfunction

  function automatic point_cmd_t read_word(int idx);
    point_cmd_t w;
    w       = random_word();
    w.cmd   = CMD_READ;
    w.index = 10'(idx);
    return w;
  endfunction

  function automatic point_cmd_t part_word(logic [1:0] ax, logic signed [31:0] plane,
                                           int lo, int hi);
    point_cmd_t w;
    w             = random_word();
    w.cmd         = CMD_PART;
    w.axis        = ax;
    w.split       = plane;
    w.range_start = 11'(lo);
    w.range_end   = 11'(hi);
    return w;
  endfunction

  function automatic int pick_window_slot();
    case ($urandom_range(3))
      0, 1:    return $urandom_range(LoTop);
      2:       return $urandom_range(Depth - 1, HiBottom);
      default: return $urandom_range(Depth - 1);
    endcase
  endfunction

  // Slot 0 is written by the directed part, so it is the fallback
  function automatic int pick_written_slot();
    int s;
    for (int k = 0; k < 16; k++) begin
      s = pick_window_slot();
      if (slot_written[s]) return s;
    end
    return 0;
  endfunction

  // Random command: mostly well-formed writes, reads and partitions
  function automatic point_cmd_t random_command();
    point_cmd_t w;
    int         r;
    int         s;
    int         e;
    int         len;
    int         idx;
    r = $urandom_range(99);
    if (r < 35) begin
      case ($urandom_range(3))
        0, 1: begin
          if (lo_fill <= LoTop) begin
            idx = lo_fill;
            lo_fill++;
          end else begin
            idx = $urandom_range(LoTop);
          end
        end
        2: begin
          if (hi_fill >= HiBottom) begin
            idx = hi_fill;
            hi_fill--;
          end else begin
            idx = $urandom_range(Depth - 1, HiBottom);
          end
        end
        default: idx = $urandom_range(Depth - 1);
      endcase
      w = write_word(idx, pick_coord(), pick_coord(), pick_coord());
    end else if (r < 65) begin
      // range over a run of written slots, mostly short
      s   = pick_written_slot();
      len = ($urandom_range(7) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
      e   = s;
      while (e < Depth && slot_written[e] && e - s < len) e++;
      w = part_word(2'($urandom_range(2)), pick_coord(), s, e);
    end else if (r < 85) begin
      w = read_word(pick_written_slot());
    end else begin
      w = random_word();
      case ($urandom_range(4))
        0: w.cmd = CmdUnknown;
        1: begin
          w.cmd  = CMD_PART;
          w.axis = AxisBad;
        end
        2: begin
          w.cmd         = CMD_PART;
          w.range_start = 11'($urandom_range(2047, 1));
          w.range_end   = 11'($urandom_range(w.range_start - 1));
        end
        3: begin
          w.cmd       = CMD_PART;
          w.range_end = 11'($urandom_range(2047, Depth + 1));
        end
        default: begin
          w.cmd         = CMD_PART;
          w.axis        = 2'($urandom_range(2));
          w.range_start = 11'($urandom_range(Depth));
          w.range_end   = w.range_start;
        end
      endcase
    end
    return w;
  endfunction

  function automatic void set_phase(int k);
    case (k % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
      default: begin src_idle_pct = 8; sink_stall_pct = 8; end
    endcase
  endfunction

  // Drive one command word and hold it until the block takes it
  task automatic issue_command(input point_cmd_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= w.cmd;
    index_i       <= w.index;
    coord_x_i     <= w.coord_x;
    coord_y_i     <= w.coord_y;
    coord_z_i     <= w.coord_z;
    axis_i        <= w.axis;
    split_i       <= w.split;
    range_start_i <= w.range_start;
    range_end_i   <= w.range_end;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(w);
  endtask

  // Extremes of the fields, every command and each corner case
  task automatic run_directed();
    point_cmd_t w;
    issue_command(write_word(0, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    issue_command(write_word(1, 32'sh7fff_ffff, 32'sh8000_0000, -1));
    issue_command(write_word(2, 1, -1, 32'sh8000_0000));
    issue_command(write_word(3, 0, 0, 32'sh7fff_ffff));
    issue_command(write_word(Depth - 1, -1, -1, -1));
    issue_command(write_word(512, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678));
    issue_command(read_word(0));
    issue_command(read_word(Depth - 1));
    issue_command(part_word(AXIS_X, 0, 0, 4));
    issue_command(part_word(AXIS_Y, 32'sh8000_0000, 0, 4));
    issue_command(part_word(AXIS_Z, 32'sh7fff_ffff, 0, 4));
    for (int k = 0; k < 4; k++) issue_command(read_word(k));
    // unknown command with every other field random
    w     = random_word();
    w.cmd = CmdUnknown;
    issue_command(w);
    issue_command(part_word(AxisBad, 0, 0, 4));
    // start past end, end past the store, both far out
    issue_command(part_word(AXIS_X, 0, 3, 2));
    issue_command(part_word(AXIS_X, 0, 0, Depth + 1));
    issue_command(part_word(AXIS_Y, 32'sh7fff_ffff, 2047, 2047));
    // empty range at the top, single slot, empty range inside
    issue_command(part_word(AXIS_Z, 0, Depth, Depth));
    issue_command(part_word(AXIS_X, 32'sh8000_0000, Depth - 1, Depth));
    issue_command(part_word(AXIS_Y, 0, 2, 2));
    issue_command(read_word(512));
  endtask

  // Result channel: check each word taken, then pick ready for the next edge
  initial begin
    res_t got;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = status_o;
        got.pt.x   = point_x_o;
        got.pt.y   = point_y_o;
        got.pt.z   = point_z_o;
        sb.check_result(got);
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CycleLimit);
    $display("point_partition_by_plane_top_tb: done, errors");
    $finish;
  end

  // Reset, stimulus and end of run
  initial begin
    sb             = new();
    lo_fill        = 4;
    hi_fill        = Depth - 2;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    cmd_i          = CMD_WRITE;
    index_i        = '0;
    coord_x_i      = '0;
    coord_y_i      = '0;
    coord_z_i      = '0;
    axis_i         = AXIS_X;
    split_i        = '0;
    range_start_i  = '0;
    range_end_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int n = 0; n < RandomWords; n++) begin
      set_phase(n / PhaseWords);
      issue_command(random_command());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("point_partition_by_plane_top_tb: done, clean");
    end else begin
      $display("point_partition_by_plane_top_tb: done, errors");
    end
    $finish;
  end

endmodule
